// File: rtl/bow_pkg.sv
// ----------------------------------------------------------------------------
// bow_pkg
// Shared types, constants and helpers for the bitrate overrun watch.
// ----------------------------------------------------------------------------
package bow_pkg;

  // Window length, alarm thresholds, counter limits and reset target
  localparam logic [63:0] WINDOW_US    = 64'd2000000;
  localparam logic [31:0] TRIP_PCT     = 32'd150;
  localparam logic [31:0] CLEAR_PCT    = 32'd120;
  localparam logic [7:0]  TRIP_WINDOWS = 8'd2;
  localparam logic [7:0]  OVER_MAX     = 8'd255;
  localparam logic [15:0] RAISED_MAX   = 16'd65535;
  localparam logic [31:0] TARGET_RESET = 32'd8192;

  // Serial divider data width (64 steps) and step counter width
  localparam int DIV_W   = 64;
  localparam int DCNT_W  = 7;

  // What the front decided for one transaction
  typedef enum logic [1:0] {
    K_IGNORE  = 2'd0,
    K_PLAIN   = 2'd1,
    K_RESTART = 2'd2,
    K_CLOSE   = 2'd3
  } kind_t;

  // Queue entry from front to back
  typedef struct packed {
    kind_t       kind;
    logic [63:0] byte_sum;
    logic [63:0] elapsed;
  } entry_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV1 = 2'd1,
    BK_DIV2 = 2'd2
  } bk_state_t;

  // x * 8000 mod 2^64 as shift-and-add: 8192 - 128 - 64
  function automatic logic [63:0] mul8000(input logic [63:0] x);
    mul8000 = (x << 13) - (x << 7) - (x << 6);
  endfunction

  // x * 100 mod 2^64 as shift-and-add: 64 + 32 + 4
  function automatic logic [63:0] mul100(input logic [63:0] x);
    mul100 = (x << 6) + (x << 5) + (x << 2);
  endfunction

endpackage

// File: rtl/bow_front.sv
// ----------------------------------------------------------------------------
// bow_front
// Accepts frames, keeps the time window and classifies each transaction.
// ----------------------------------------------------------------------------
module bow_front
  import bow_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] target_kbps,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] frame_len,
  input  logic [63:0] now_us,
  input  logic        q_full,
  output logic        q_push,
  output entry_t      q_entry
);

  logic [63:0] window_start;
  logic [63:0] window_byte_sum;
  logic [63:0] window_start_next;
  logic [63:0] window_byte_sum_next;
  logic [63:0] ws_eff;
  logic [63:0] sum_add;
  logic [63:0] elapsed;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  // Window start taken from this frame when not yet started
  assign ws_eff  = (window_start == 64'd0) ? now_us : window_start;
  assign sum_add = window_byte_sum + {32'd0, frame_len};
  assign elapsed = now_us - ws_eff;

  // Classification
  always_comb begin
    window_start_next    = window_start;
    window_byte_sum_next = window_byte_sum;
    q_entry.kind         = K_IGNORE;
    q_entry.byte_sum     = sum_add;
    q_entry.elapsed      = elapsed;
    if (target_kbps != 32'd0) begin
      priority if (now_us < ws_eff) begin
        q_entry.kind         = K_RESTART;
        window_start_next    = now_us;
        window_byte_sum_next = 64'd0;
      end else if (elapsed >= WINDOW_US) begin
        q_entry.kind         = K_CLOSE;
        window_start_next    = now_us;
        window_byte_sum_next = 64'd0;
      end else begin
        q_entry.kind         = K_PLAIN;
        window_start_next    = ws_eff;
        window_byte_sum_next = sum_add;
      end
    end
  end

  // Window state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start    <= 64'd0;
      window_byte_sum <= 64'd0;
    end else if (accept) begin
      window_start    <= window_start_next;
      window_byte_sum <= window_byte_sum_next;
    end
  end

endmodule

// File: rtl/bow_fifo.sv
// ----------------------------------------------------------------------------
// bow_fifo
// Short register queue between the front and the back (DEPTH >= 2).
// ----------------------------------------------------------------------------
module bow_fifo
  import bow_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_data,
  output logic   full,
  input  logic   pop,
  output entry_t rd_data,
  output logic   not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_data   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/bow_div.sv
// ----------------------------------------------------------------------------
// bow_div
// 64-bit unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bow_div
  import bow_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dsr;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    rem_sub;
  logic              q_bit;

  // One shift-subtract step; quotient bits shift into quot
  assign rem_sh  = {rem, quot[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign q_bit   = (rem_sh >= {1'b0, dsr});

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dsr  <= divisor;
      quot <= dividend;
    end else if (busy) begin
      rem  <= q_bit ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quot <= {quot[DIV_W-2:0], q_bit};
    end
  end

endmodule

// File: rtl/bow_back.sv
// ----------------------------------------------------------------------------
// bow_back
// Evaluates closed windows, keeps the alarm state and holds the result.
// ----------------------------------------------------------------------------
module bow_back
  import bow_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] target_kbps,
  input  logic        q_valid,
  input  entry_t      q_entry,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        window_closed,
  output logic        window_restarted,
  output logic [31:0] ratio_pct,
  output logic        alarm_active,
  output logic        alarm_raised,
  output logic        alarm_cleared,
  output logic [15:0] alarm_count,
  output logic [7:0]  over_count
);

  bk_state_t   state;
  bk_state_t   state_next;
  logic [7:0]  over_streak;
  logic [7:0]  over_streak_next;
  logic        alarm_flag;
  logic        alarm_flag_next;
  logic [15:0] raised_total;
  logic [15:0] raised_total_next;

  logic        slot_free;
  logic        load_out;
  logic        res_closed;
  logic        res_restarted;
  logic [31:0] res_ratio;
  logic        res_raised;
  logic        res_cleared;

  logic        div_start;
  logic [63:0] div_dividend;
  logic [63:0] div_divisor;
  logic        div_done;
  logic [63:0] div_quot;

  // Shared serial divider: bytes*8000/elapsed, then kbps*100/target
  bow_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign slot_free = !out_valid || out_ready;

  // Sequencer and alarm evaluation
  always_comb begin
    state_next        = state;
    q_pop             = 1'b0;
    div_start         = 1'b0;
    div_dividend      = '0;
    div_divisor       = '0;
    load_out          = 1'b0;
    res_closed        = 1'b0;
    res_restarted     = 1'b0;
    res_ratio         = '0;
    res_raised        = 1'b0;
    res_cleared       = 1'b0;
    over_streak_next  = over_streak;
    alarm_flag_next   = alarm_flag;
    raised_total_next = raised_total;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          if (q_entry.kind == K_CLOSE) begin
            div_start    = 1'b1;
            div_dividend = mul8000(q_entry.byte_sum);
            div_divisor  = q_entry.elapsed;
            state_next   = BK_DIV1;
          end else begin
            load_out      = 1'b1;
            res_restarted = (q_entry.kind == K_RESTART);
          end
        end
      end
      BK_DIV1: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = mul100(div_quot);
          div_divisor  = {32'd0, target_kbps};
          state_next   = BK_DIV2;
        end
      end
      BK_DIV2: begin
        if (div_done) begin
          load_out   = 1'b1;
          res_closed = 1'b1;
          res_ratio  = div_quot[31:0];
          state_next = BK_IDLE;
          // Over threshold: count, raise after enough windows; at or under the clear level, reset and clear
          priority if (res_ratio >= TRIP_PCT) begin
            if (over_streak < OVER_MAX) begin
              over_streak_next = over_streak + 8'd1;
            end
            if (over_streak_next >= TRIP_WINDOWS && !alarm_flag) begin
              alarm_flag_next = 1'b1;
              res_raised      = 1'b1;
              if (raised_total < RAISED_MAX) begin
                raised_total_next = raised_total + 16'd1;
              end
            end
          end else if (res_ratio <= CLEAR_PCT) begin
            res_cleared      = alarm_flag;
            over_streak_next = 8'd0;
            alarm_flag_next  = 1'b0;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      over_streak  <= 8'd0;
      alarm_flag   <= 1'b0;
      raised_total <= 16'd0;
    end else begin
      state        <= state_next;
      over_streak  <= over_streak_next;
      alarm_flag   <= alarm_flag_next;
      raised_total <= raised_total_next;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      window_closed    <= res_closed;
      window_restarted <= res_restarted;
      ratio_pct        <= res_ratio;
      alarm_active     <= alarm_flag_next;
      alarm_raised     <= res_raised;
      alarm_cleared    <= res_cleared;
      alarm_count      <= raised_total_next;
      over_count       <= over_streak_next;
    end
  end

endmodule

// File: rtl/bitrate_overrun_watch.sv
// ----------------------------------------------------------------------------
// bitrate_overrun_watch
// Frames arrive with a byte count and a microsecond timestamp and are summed
// into a window that opens at the first nonzero timestamp. When the window
// spans 2 s or more, the delivered kbps and its percentage of target_kbps are
// computed; 150% or more in two windows with no window at 120% or less between
// raises the alarm, 120% or less clears it. A timestamp before the window start
// restarts the window and drops that frame's bytes; a zero target makes frames
// pass without effect. Every frame yields exactly one result. The front accepts
// one frame per cycle while the QUEUE_DEPTH entry queue has room. In the back, a
// frame that does not close a window goes straight to the result register; a
// closing frame holds the back while the shared bit-serial 64-bit divider runs
// twice (64 steps each) and the result is then loaded. The back takes the next
// frame only once the last result is loaded and the output register is free.
// ----------------------------------------------------------------------------
module bitrate_overrun_watch
  import bow_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] frame_len,
  input  logic [63:0] now_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        window_closed,
  output logic        window_restarted,
  output logic [31:0] ratio_pct,
  output logic        alarm_active,
  output logic        alarm_raised,
  output logic        alarm_cleared,
  output logic [15:0] alarm_count,
  output logic [7:0]  over_count
);

  logic [31:0] target_kbps;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  entry_t      q_wr_entry;
  entry_t      q_rd_entry;

  // Target register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_kbps <= TARGET_RESET;
    end else if (cfg_wr_en) begin
      target_kbps <= cfg_wr_data;
    end
  end

  // Front: window tracking and classification
  bow_front u_front (
    .clk         (clk),
    .rst         (rst),
    .target_kbps (target_kbps),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .frame_len   (frame_len),
    .now_us      (now_us),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_wr_entry)
  );

  // Queue between front and back
  bow_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_data   (q_wr_entry),
    .full      (q_full),
    .pop       (q_pop),
    .rd_data   (q_rd_entry),
    .not_empty (q_valid)
  );

  // Back: ratio, alarm and result register
  bow_back u_back (
    .clk              (clk),
    .rst              (rst),
    .target_kbps      (target_kbps),
    .q_valid          (q_valid),
    .q_entry          (q_rd_entry),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .window_closed    (window_closed),
    .window_restarted (window_restarted),
    .ratio_pct        (ratio_pct),
    .alarm_active     (alarm_active),
    .alarm_raised     (alarm_raised),
    .alarm_cleared    (alarm_cleared),
    .alarm_count      (alarm_count),
    .over_count       (over_count)
  );

  // A transaction never both closes and restarts a window
  a_closed_xor_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(window_closed && window_restarted))
    else $error("window closed and restarted on one transaction");

  // Alarm pulses agree with the alarm state they report
  a_pulse_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!alarm_raised || alarm_active) && (!alarm_cleared || !alarm_active))
    else $error("alarm pulse disagrees with alarm state");

  // Only an evaluated window carries a ratio, and only a high one raises
  a_ratio_only_closed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !window_closed |-> ratio_pct == 32'd0 && !alarm_raised && !alarm_cleared)
    else $error("ratio or alarm pulse without a closed window");

  a_raise_threshold: assert property (@(posedge clk) disable iff (rst)
    out_valid && alarm_raised |-> ratio_pct >= TRIP_PCT && over_count >= TRIP_WINDOWS)
    else $error("alarm raised below threshold");

endmodule
